// File: design/dtmr_pkg.sv
// ----------------------------------------------------------------------------
// Device tree memory region parser package
// Shared word types, token codes, parse phases and name matching helpers.
// ----------------------------------------------------------------------------
package dtmr_pkg;

    typedef struct packed {
        logic [31:0] blob_word;
        logic        last_word;
    } in_word_t;

    typedef struct packed {
        logic        kind;
        logic [63:0] region_base;
        logic [63:0] region_size;
        logic [3:0]  entry_index;
        logic        status;
        logic [4:0]  entry_count;
    } result_t;

    typedef struct packed {
        logic    valid0;
        logic    valid1;
        result_t res0;
        result_t res1;
    } push_t;

    typedef enum logic [6:0] {
        PH_HEADER = 7'b0000001,
        PH_SKIP   = 7'b0000010,
        PH_TOKEN  = 7'b0000100,
        PH_NAME   = 7'b0001000,
        PH_PLEN   = 7'b0010000,
        PH_POFF   = 7'b0100000,
        PH_PDATA  = 7'b1000000
    } phase_t;

    localparam logic [31:0] BLOB_MAGIC   = 32'hd00dfeed;
    localparam logic [31:0] TK_BEGIN     = 32'h1;
    localparam logic [31:0] TK_ENDNODE   = 32'h2;
    localparam logic [31:0] TK_PROP      = 32'h3;
    localparam logic [31:0] TK_NOP       = 32'h4;
    localparam logic [31:0] TK_END       = 32'h9;
    localparam logic [31:0] HEADER_BYTES = 32'd40;
    localparam logic [29:0] HDR_IDX_MAGIC = 30'd0;
    localparam logic [29:0] HDR_IDX_OFF   = 30'd2;
    localparam logic [29:0] HDR_IDX_SIZE  = 30'd9;
    localparam logic [2:0]  NAME_POS_FULL = 3'd6;
    localparam logic [2:0]  NAME_POS_AT   = 3'd7;
    localparam logic [7:0]  CHAR_AT       = 8'h40;

    localparam logic       CFG_MAX_ENTRIES = 1'b0;
    localparam logic       CFG_REG_NAME    = 1'b1;
    localparam logic [4:0] MAX_ENTRIES_RST = 5'd16;

    function automatic logic [7:0] mem_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h6d;
            3'd1:    c = 8'h65;
            3'd2:    c = 8'h6d;
            3'd3:    c = 8'h6f;
            3'd4:    c = 8'h72;
            3'd5:    c = 8'h79;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: design/dtmr_parse.sv
// ----------------------------------------------------------------------------
// Device tree memory region parser: word parser
// Consumes one blob word per accepted cycle and produces up to two results.
// ----------------------------------------------------------------------------
module dtmr_parse #(
    parameter int STACK_DEPTH = 16,
    parameter int MAX_REGIONS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  dtmr_pkg::in_word_t in_word,
    input  logic [4:0]         max_entries,
    input  logic [15:0]        reg_name_offset,
    output dtmr_pkg::push_t    push
);
    import dtmr_pkg::*;

    localparam int DW = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
    localparam int LIM_CAP = (MAX_REGIONS < 31) ? MAX_REGIONS : 31;
    localparam logic [4:0] LIM_CAP5 = 5'(LIM_CAP);
    localparam logic [DW-1:0] DEPTH_TOP = DW'(STACK_DEPTH - 1);

    phase_t              phase_reg, phase_next;
    logic [31:0]         off_reg, off_next;
    logic [31:0]         start_reg, start_next;
    logic [31:0]         end_reg, end_next;
    logic [DW-1:0]       depth_reg, depth_next;
    logic [STACK_DEPTH-1:0] stack_reg;
    logic [2:0]          pos_reg, pos_next;
    logic                mism_reg, mism_next;
    logic [31:0]         left_reg, left_next;
    logic                cap_reg, cap_next;
    logic [1:0]          pwi_reg, pwi_next;
    logic [63:0]         base_reg, base_next;
    logic [31:0]         szh_reg, szh_next;
    logic [4:0]          found_reg, found_next;
    logic                fin_reg, fin_next;

    logic                stk_we, stk_wd, stk_clr;
    logic                fin_fire, fin_st;
    logic [4:0]          limit;
    logic [31:0]         word;

    assign word  = in_word.blob_word;
    assign limit = (max_entries < LIM_CAP5) ? max_entries : LIM_CAP5;

    always_comb
    begin
        logic [7:0] c;
        logic       stop;
        result_t    stat;
        phase_next = phase_reg;
        off_next   = off_reg;
        start_next = start_reg;
        end_next   = end_reg;
        depth_next = depth_reg;
        pos_next   = pos_reg;
        mism_next  = mism_reg;
        left_next  = left_reg;
        cap_next   = cap_reg;
        pwi_next   = pwi_reg;
        base_next  = base_reg;
        szh_next   = szh_reg;
        found_next = found_reg;
        fin_next   = fin_reg;
        stk_we     = 1'b0;
        stk_wd     = 1'b0;
        stk_clr    = 1'b0;
        fin_fire   = 1'b0;
        fin_st     = 1'b0;
        stop       = 1'b0;
        c          = 8'h00;
        stat       = '0;
        push       = '0;
        if (!fin_reg)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (off_reg[31:2] == HDR_IDX_MAGIC && word != BLOB_MAGIC)
                    begin
                        fin_fire = 1'b1;
                        fin_st   = 1'b1;
                    end
                    else if (off_reg[31:2] == HDR_IDX_OFF)
                    begin
                        start_next = word;
                    end
                    else if (off_reg[31:2] == HDR_IDX_SIZE)
                    begin
                        end_next = start_reg + word;
                        if (start_reg < HEADER_BYTES || start_reg[1:0] != 2'b00)
                        begin
                            fin_fire = 1'b1;
                            fin_st   = 1'b1;
                        end
                        else
                        begin
                            phase_next = (start_reg == HEADER_BYTES) ? PH_TOKEN : PH_SKIP;
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (off_reg + 32'd4 == start_reg)
                    begin
                        phase_next = PH_TOKEN;
                    end
                end
                PH_TOKEN:
                begin
                    case (word)
                        TK_BEGIN:
                        begin
                            if (depth_reg == DEPTH_TOP)
                            begin
                                fin_fire = 1'b1;
                                fin_st   = 1'b1;
                            end
                            else
                            begin
                                depth_next = depth_reg + 1'b1;
                                pos_next   = 3'd0;
                                mism_next  = 1'b0;
                                phase_next = PH_NAME;
                            end
                        end
                        TK_ENDNODE:
                        begin
                            if (depth_reg != '0)
                            begin
                                depth_next = depth_reg - 1'b1;
                            end
                        end
                        TK_PROP:
                        begin
                            phase_next = PH_PLEN;
                        end
                        TK_NOP:
                        begin
                        end
                        TK_END:
                        begin
                            fin_fire = 1'b1;
                        end
                        default:
                        begin
                            fin_fire = 1'b1;
                            fin_st   = 1'b1;
                        end
                    endcase
                end
                PH_NAME:
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        c = word[31-8*k -: 8];
                        if (!stop)
                        begin
                            if (c == 8'h00)
                            begin
                                stk_we = 1'b1;
                                stk_wd = (pos_next == NAME_POS_AT)
                                    || (pos_next == NAME_POS_FULL && !mism_next);
                                phase_next = PH_TOKEN;
                                stop = 1'b1;
                            end
                            else if (!mism_next && pos_next != NAME_POS_AT)
                            begin
                                if (pos_next < NAME_POS_FULL)
                                begin
                                    if (c == mem_char(pos_next))
                                    begin
                                        pos_next = pos_next + 3'd1;
                                    end
                                    else
                                    begin
                                        mism_next = 1'b1;
                                    end
                                end
                                else if (c == CHAR_AT)
                                begin
                                    pos_next = NAME_POS_AT;
                                end
                                else
                                begin
                                    mism_next = 1'b1;
                                end
                            end
                        end
                    end
                end
                PH_PLEN:
                begin
                    left_next  = word;
                    phase_next = PH_POFF;
                end
                PH_POFF:
                begin
                    cap_next   = stack_reg[depth_reg] && (word == {16'h0000, reg_name_offset});
                    pwi_next   = 2'd0;
                    phase_next = (left_reg == 32'd0) ? PH_TOKEN : PH_PDATA;
                end
                PH_PDATA:
                begin
                    if (cap_reg)
                    begin
                        case (pwi_reg)
                            2'd0:    base_next = {word, 32'h0};
                            2'd1:    base_next = {base_reg[63:32], word};
                            2'd2:    szh_next  = word;
                            default:
                            begin
                                if (left_reg >= 32'd4 && found_reg < limit)
                                begin
                                    found_next               = found_reg + 5'd1;
                                    push.valid0              = 1'b1;
                                    push.res0.kind           = 1'b0;
                                    push.res0.region_base    = base_reg;
                                    push.res0.region_size    = {szh_reg, word};
                                    push.res0.entry_index    = found_reg[3:0];
                                    push.res0.status         = 1'b0;
                                    push.res0.entry_count    = found_reg + 5'd1;
                                end
                            end
                        endcase
                        pwi_next = pwi_reg + 2'd1;
                    end
                    left_next = (left_reg > 32'd4) ? left_reg - 32'd4 : 32'd0;
                    if (left_reg <= 32'd4)
                    begin
                        phase_next = PH_TOKEN;
                    end
                end
                default:
                begin
                end
            endcase
            off_next = off_reg + 32'd4;
            if (!fin_fire && phase_next == PH_TOKEN && off_next >= end_next)
            begin
                fin_fire = 1'b1;
            end
            if (!fin_fire && in_word.last_word)
            begin
                fin_fire = 1'b1;
                fin_st   = 1'b1;
            end
            if (fin_fire)
            begin
                fin_next         = 1'b1;
                stat.kind        = 1'b1;
                stat.status      = fin_st;
                stat.entry_count = found_next;
                if (push.valid0)
                begin
                    push.valid1 = 1'b1;
                    push.res1   = stat;
                end
                else
                begin
                    push.valid0 = 1'b1;
                    push.res0   = stat;
                end
            end
        end
        if (in_word.last_word)
        begin
            stk_clr    = 1'b1;
            phase_next = PH_HEADER;
            off_next   = '0;
            start_next = '0;
            end_next   = '0;
            depth_next = '0;
            pos_next   = '0;
            mism_next  = 1'b0;
            left_next  = '0;
            cap_next   = 1'b0;
            pwi_next   = '0;
            base_next  = '0;
            szh_next   = '0;
            found_next = '0;
            fin_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            off_reg   <= '0;
            start_reg <= '0;
            end_reg   <= '0;
            depth_reg <= '0;
            stack_reg <= '0;
            pos_reg   <= '0;
            mism_reg  <= 1'b0;
            left_reg  <= '0;
            cap_reg   <= 1'b0;
            pwi_reg   <= '0;
            base_reg  <= '0;
            szh_reg   <= '0;
            found_reg <= '0;
            fin_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            off_reg   <= off_next;
            start_reg <= start_next;
            end_reg   <= end_next;
            depth_reg <= depth_next;
            pos_reg   <= pos_next;
            mism_reg  <= mism_next;
            left_reg  <= left_next;
            cap_reg   <= cap_next;
            pwi_reg   <= pwi_next;
            base_reg  <= base_next;
            szh_reg   <= szh_next;
            found_reg <= found_next;
            fin_reg   <= fin_next;
            if (stk_clr)
            begin
                stack_reg <= '0;
            end
            else if (stk_we)
            begin
                stack_reg[depth_reg] <= stk_wd;
            end
        end
    end

`ifndef SYNTH
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(depth_reg) < STACK_DEPTH)
        else $error("node depth out of range");
    a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(found_reg) <= MAX_REGIONS)
        else $error("region count above limit");
    a_second_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid1 |-> (push.valid0 && !push.res0.kind && push.res1.kind))
        else $error("second result must be a status after a region");
    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_reg && !in_word.last_word) |-> !push.valid0)
        else $error("result after end of run");
`endif

endmodule

// File: design/dtmr_outq.sv
// ----------------------------------------------------------------------------
// Device tree memory region parser: result queue
// Four-word queue taking up to two results per cycle while it has room and giving one while out_ready is high.
// ----------------------------------------------------------------------------
module dtmr_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_en,
    input  dtmr_pkg::push_t   push,
    output logic              space,
    output logic              out_valid,
    input  logic              out_ready,
    output dtmr_pkg::result_t out_data
);
    import dtmr_pkg::*;

    result_t    mem_reg [4];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    logic [1:0] n_push;

    assign space     = (cnt_reg <= 3'd2);
    assign out_valid = (cnt_reg != 3'd0);
    assign out_data  = mem_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    assign n_push    = push_en ? ({1'b0, push.valid0} + {1'b0, push.valid1}) : 2'd0;
    assign wr_next   = wr_reg + n_push;
    assign rd_next   = rd_reg + {1'b0, pop};
    assign cnt_next  = cnt_reg + {1'b0, n_push} - {2'b00, pop};

    always_ff @(posedge clk)
    begin
        if (push_en && push.valid0)
        begin
            mem_reg[wr_reg] <= push.res0;
        end
        if (push_en && push.valid1)
        begin
            mem_reg[wr_reg + 2'd1] <= push.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("queue overflow");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_reg - rd_reg) == cnt_reg[1:0])
        else $error("queue pointers disagree with count");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push_en |-> space)
        else $error("push without room");
`endif

endmodule

// File: design/device_tree_memory_region_parser_core.sv
// ----------------------------------------------------------------------------
// Device tree memory region parser
// Streams a flattened device tree blob and reports its memory regions.
// ----------------------------------------------------------------------------
// Usage: blob words enter on in_valid/in_ready, one word per cycle while in_ready is
// high, from byte offset zero, with last_word set on the final word of a blob. Each
// region found inside a memory node's reg property, up to max_entries and MAX_REGIONS,
// leaves as one word on out_valid/out_ready, and every run closes with one status word.
// The block takes one word per cycle while in_ready is high. A result is visible on
// the output in the cycle after the word that causes it is taken. A word may cause
// two results, a region and the closing status, and both land in a four-entry result
// queue; in_ready drops while fewer than two queue entries are free, so a stalled
// receiver holds the input back after at most four words of results.
// The user must write the configuration registers max_entries and reg_name_offset
// through cfg_we, cfg_index and cfg_data only while the block is idle; the block
// itself does not enforce this. Reset empties the queue, returns the parser to the
// header and sets max_entries to 16 and reg_name_offset to 0.
// ----------------------------------------------------------------------------
module device_tree_memory_region_parser_core #(
    parameter int STACK_DEPTH = 16,
    parameter int MAX_REGIONS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dtmr_pkg::in_word_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output dtmr_pkg::result_t out_data,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_data
);
    import dtmr_pkg::*;

    logic [4:0]  max_entries_reg;
    logic [15:0] reg_name_reg;
    logic        accept;
    push_t       push;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= MAX_ENTRIES_RST;
            reg_name_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_ENTRIES: max_entries_reg <= cfg_data[4:0];
                CFG_REG_NAME:    reg_name_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    dtmr_parse #(
        .STACK_DEPTH (STACK_DEPTH),
        .MAX_REGIONS (MAX_REGIONS)
    ) u_parse (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .in_word         (in_data),
        .max_entries     (max_entries_reg),
        .reg_name_offset (reg_name_reg),
        .push            (push)
    );

    dtmr_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (accept),
        .push      (push),
        .space     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
